@@ rtl/core/bfd_pkg.sv @@
// Shared types, constants and command/status structs of the byte frame deframer.
package bfd_pkg;

  localparam int PAYLOAD_DEPTH = 32;
  localparam int MAX_RUN       = 32;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
  localparam int LIMIT_CAP_I   = (PAYLOAD_DEPTH < MAX_RUN) ? PAYLOAD_DEPTH : MAX_RUN;
  localparam logic [5:0] LIMIT_CAP = 6'(LIMIT_CAP_I);

  localparam int CFG_IDX_W = 4;

  localparam logic [7:0] START_BYTE_RST  = 8'd170;
  localparam logic [7:0] END_BYTE_RST    = 8'd85;
  localparam logic [5:0] MAX_LEN_RST     = 6'd32;
  localparam logic [7:0] TIMEOUT_RST     = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE = 4'd0,
    CFG_END_BYTE   = 4'd1,
    CFG_MAX_LEN    = 4'd2,
    CFG_TIMEOUT    = 4'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_LEN_LONG = 3'd1,
    STAT_TIMEOUT  = 3'd2,
    STAT_BAD_END  = 3'd3,
    STAT_BAD_SUM  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_HUNT,
    S_ID,
    S_LEN,
    S_DATA,
    S_SUM,
    S_END,
    S_READ,
    S_SEND
  } state_t;

  typedef struct packed {
    logic    load_id;
    logic    load_len;
    logic    load_data;
    logic    load_sum;
    logic    tick_inc;
    logic    emit;
    status_t emit_code;
    logic    emit_payload;
    logic    replay_clear;
    logic    replay_read;
    logic    replay_next;
  } dp_cmd_t;

  typedef struct packed {
    logic start_hit;
    logic len_over;
    logic len_zero;
    logic frame_empty;
    logic data_done;
    logic tick_expired;
    logic end_ok;
    logic sum_ok;
    logic replay_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/bfd_if.sv @@
// Valid/ready channel interfaces: input items, result items and register writes.
interface bfd_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface bfd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] msg_id;
  logic [7:0] frame_length;
  logic [7:0] payload_byte;
  logic [4:0] byte_index;
  logic       last;
  modport source (output valid, status, msg_id, frame_length, payload_byte, byte_index, last,
                  input ready);
  modport sink (input valid, status, msg_id, frame_length, payload_byte, byte_index, last,
                output ready);
endinterface

interface bfd_cfg_if import bfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/byte_frame_deframer_xor_check_unit.sv @@
// Top level of the byte frame deframer with XOR checksum.
// Each input item (a received byte or a time tick) is taken whenever the result register is
// empty or being drained in that cycle; faulted frames give a single status result loaded in
// the same cycle as the byte or tick that ends them. After a good end byte the payload is replayed
// from the payload memory, each byte through a memory read step (the read port is registered)
// and then a result-load step that waits for a free result register; no input is taken during
// the replay. An empty valid frame gives its one result immediately. The payload memory
// needs no clearing after reset; registers can be written at any time through the cfg channel.
module byte_frame_deframer_xor_check_unit import bfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bfd_item_if.sink     item,
  bfd_result_if.source result,
  bfd_cfg_if.sink      cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     item_ready;

  assign item.ready = item_ready;

  bfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_kind  (item.kind),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bfd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (item.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

@@ rtl/core/bfd_ctrl.sv @@
// Frame controller: phase tracking, timeout decisions and payload replay sequencing.
module bfd_ctrl import bfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  logic     item_kind,
  output logic     item_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  logic   in_phase;
  logic   acc;
  logic   tick_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

  assign in_phase   = (state != S_READ) && (state != S_SEND);
  assign tick_phase = (state == S_DATA) || (state == S_SUM) || (state == S_END);
  assign item_ready = in_phase && stat.out_free;
  assign acc        = item_valid && item_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (acc && item_kind) begin
      // ticks only count once the length is known
      if (tick_phase) begin
        if (stat.tick_expired) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = STAT_TIMEOUT;
          state_next    = S_HUNT;
        end else begin
          cmd.tick_inc = 1'b1;
        end
      end
    end else if (acc) begin
      case (state)
        S_HUNT: begin
          if (stat.start_hit) state_next = S_ID;
        end
        S_ID: begin
          cmd.load_id = 1'b1;
          state_next  = S_LEN;
        end
        S_LEN: begin
          cmd.load_len = 1'b1;
          if (stat.len_over) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = STAT_LEN_LONG;
            state_next    = S_HUNT;
          end else if (stat.len_zero) begin
            state_next = S_SUM;
          end else begin
            state_next = S_DATA;
          end
        end
        S_DATA: begin
          cmd.load_data = 1'b1;
          if (stat.data_done) state_next = S_SUM;
        end
        S_SUM: begin
          cmd.load_sum = 1'b1;
          state_next   = S_END;
        end
        S_END: begin
          state_next = S_HUNT;
          if (!stat.end_ok) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = STAT_BAD_END;
          end else if (!stat.sum_ok) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = STAT_BAD_SUM;
          end else if (stat.frame_empty) begin
            cmd.emit      = 1'b1;
            cmd.emit_code = STAT_OK;
          end else begin
            cmd.replay_clear = 1'b1;
            state_next       = S_READ;
          end
        end
        default: state_next = S_HUNT;
      endcase
    end else begin
      case (state)
        S_READ: begin
          cmd.replay_read = 1'b1;
          state_next      = S_SEND;
        end
        S_SEND: begin
          if (stat.out_free) begin
            cmd.emit         = 1'b1;
            cmd.emit_code    = STAT_OK;
            cmd.emit_payload = 1'b1;
            if (stat.replay_last) begin
              state_next = S_HUNT;
            end else begin
              cmd.replay_next = 1'b1;
              state_next      = S_READ;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output register still occupied");

  a_no_input_in_replay: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_SEND) |-> !item_ready)
    else $error("input taken during payload replay");

  a_replay_from_end: assert property (@(posedge clk) disable iff (rst)
    cmd.replay_clear |=> (state == S_READ))
    else $error("replay start did not enter read step");

endmodule

@@ rtl/core/bfd_dp.sv @@
// Datapath: config registers, frame fields, checksum, payload memory and result register.
module bfd_dp import bfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    data_byte,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat,
  bfd_cfg_if.sink       cfg,
  bfd_result_if.source  result
);

  logic [7:0]       start_byte;
  logic [7:0]       end_byte;
  logic [5:0]       max_payload_len;
  logic [7:0]       timeout_ticks;
  logic [5:0]       len_limit;

  logic [7:0]       frame_id;
  logic [7:0]       frame_length;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       running_xor;
  logic [7:0]       received_sum;
  logic [7:0]       tick_count;
  logic [ADDR_W-1:0] rd_idx;

  logic [7:0]       mem [PAYLOAD_DEPTH];
  logic [7:0]       rd_data;

  logic             out_valid;
  status_t          res_status;
  logic [7:0]       res_msg_id;
  logic [7:0]       res_frame_length;
  logic [7:0]       res_payload;
  logic [4:0]       res_index;
  logic             res_last;

  assign cfg.ready = 1'b1;

  assign len_limit = (max_payload_len > LIMIT_CAP) ? LIMIT_CAP : max_payload_len;

  always_comb begin
    stat.start_hit    = (data_byte == start_byte);
    stat.len_over     = (data_byte > {2'b00, len_limit});
    stat.len_zero     = (data_byte == 8'd0);
    stat.frame_empty  = (frame_length == 8'd0);
    stat.data_done    = ((8'(byte_count) + 8'd1) >= frame_length);
    stat.tick_expired = (tick_count >= timeout_ticks);
    stat.end_ok       = (data_byte == end_byte);
    stat.sum_ok       = (received_sum == running_xor);
    stat.replay_last  = ((8'(rd_idx) + 8'd1) == frame_length);
    stat.out_free     = !out_valid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= START_BYTE_RST;
      end_byte        <= END_BYTE_RST;
      max_payload_len <= MAX_LEN_RST;
      timeout_ticks   <= TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_START_BYTE: start_byte      <= cfg.data;
        CFG_END_BYTE:   end_byte        <= cfg.data;
        CFG_MAX_LEN:    max_payload_len <= cfg.data[5:0];
        CFG_TIMEOUT:    timeout_ticks   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id     <= '0;
      frame_length <= '0;
      byte_count   <= '0;
      running_xor  <= '0;
      received_sum <= '0;
      tick_count   <= '0;
      rd_idx       <= '0;
    end else begin
      if (cmd.load_id) begin
        frame_id    <= data_byte;
        running_xor <= data_byte;
      end
      if (cmd.load_len) begin
        frame_length <= data_byte;
        running_xor  <= running_xor ^ data_byte;
        byte_count   <= '0;
        tick_count   <= '0;
      end
      if (cmd.load_data) begin
        running_xor <= running_xor ^ data_byte;
        byte_count  <= byte_count + CNT_W'(1);
      end
      if (cmd.load_sum) received_sum <= data_byte;
      if (cmd.tick_inc) tick_count <= tick_count + 8'd1;
      if (cmd.replay_clear) begin
        rd_idx <= '0;
      end else if (cmd.replay_next) begin
        rd_idx <= rd_idx + ADDR_W'(1);
      end
    end
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_data && (byte_count < CNT_W'(PAYLOAD_DEPTH))) begin
      mem[byte_count[ADDR_W-1:0]] <= data_byte;
    end
    if (cmd.replay_read) rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_status       <= cmd.emit_code;
      res_msg_id       <= frame_id;
      // a length fault reports the length byte taken in this same cycle
      res_frame_length <= cmd.load_len ? data_byte : frame_length;
      res_payload      <= cmd.emit_payload ? rd_data : 8'd0;
      res_index        <= cmd.emit_payload ? 5'(rd_idx) : 5'd0;
      res_last         <= cmd.emit_payload ? stat.replay_last : 1'b1;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = res_status;
  assign result.msg_id       = res_msg_id;
  assign result.frame_length = res_frame_length;
  assign result.payload_byte = res_payload;
  assign result.byte_index   = res_index;
  assign result.last         = res_last;

  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_data |-> (byte_count < CNT_W'(PAYLOAD_DEPTH)))
    else $error("payload write beyond store depth");

  a_replay_within_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.replay_read |-> (8'(rd_idx) < frame_length))
    else $error("replay read past frame length");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> (out_valid && $stable({res_status, res_msg_id,
      res_frame_length, res_payload, res_index, res_last})))
    else $error("waiting result changed before transfer");

endmodule

@@ dv/frame_checker.sv @@
// Checker for the byte frame deframer: predicts results from observed transfers and compares.
module frame_checker import bfd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  bfd_item_if   item,
  bfd_result_if result,
  bfd_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding
);

  typedef enum logic [2:0] {
    HUNT,
    TAKE_ID,
    TAKE_LEN,
    TAKE_DATA,
    TAKE_SUM,
    TAKE_END
  } rx_phase_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] msg_id;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       last;
  } frame_result_t;

  // Register copies
  logic [7:0] start_byte;
  logic [7:0] end_byte;
  logic [5:0] max_len;
  logic [7:0] timeout;

  // Deframer state
  rx_phase_t  rx_phase;
  logic [7:0] cur_id;
  logic [7:0] cur_len;
  logic [5:0] byte_count;
  logic [7:0] run_xor;
  logic [7:0] rx_sum;
  logic [7:0] tick_count;
  logic [7:0] payload [PAYLOAD_DEPTH];

  frame_result_t awaited_results[$];

  task automatic push_result(input status_t st, input logic [7:0] pb, input logic [4:0] idx,
                             input logic lst);
    frame_result_t r;
    r.status       = st;
    r.msg_id       = cur_id;
    r.frame_length = cur_len;
    r.payload_byte = pb;
    r.byte_index   = idx;
    r.last         = lst;
    awaited_results.push_back(r);
  endtask

  task automatic abandon(input status_t st);
    push_result(st, 8'd0, 5'd0, 1'b1);
    rx_phase = HUNT;
  endtask

  task automatic deframe_step(input logic is_tick, input logic [7:0] b);
    logic [5:0] limit;
    int         i;
    limit = (max_len > LIMIT_CAP) ? LIMIT_CAP : max_len;
    if (is_tick) begin
      // ticks only count once the length is known
      if (rx_phase inside {TAKE_DATA, TAKE_SUM, TAKE_END}) begin
        if (tick_count >= timeout) abandon(STAT_TIMEOUT);
        else tick_count++;
      end
    end else begin
      case (rx_phase)
        HUNT: begin
          if (b == start_byte) rx_phase = TAKE_ID;
        end
        TAKE_ID: begin
          cur_id   = b;
          run_xor  = b;
          rx_phase = TAKE_LEN;
        end
        TAKE_LEN: begin
          cur_len = b;
          if (b > limit) begin
            abandon(STAT_LEN_LONG);
          end else begin
            run_xor    = run_xor ^ b;
            byte_count = '0;
            tick_count = '0;
            rx_phase   = (b == 8'd0) ? TAKE_SUM : TAKE_DATA;
          end
        end
        TAKE_DATA: begin
          if (byte_count < PAYLOAD_DEPTH) payload[byte_count[ADDR_W-1:0]] = b;
          run_xor    = run_xor ^ b;
          byte_count = byte_count + 6'd1;
          if (byte_count >= cur_len) rx_phase = TAKE_SUM;
        end
        TAKE_SUM: begin
          rx_sum   = b;
          rx_phase = TAKE_END;
        end
        TAKE_END: begin
          if (b != end_byte) begin
            abandon(STAT_BAD_END);
          end else if (rx_sum != run_xor) begin
            abandon(STAT_BAD_SUM);
          end else begin
            rx_phase = HUNT;
            if (cur_len == 8'd0) begin
              push_result(STAT_OK, 8'd0, 5'd0, 1'b1);
            end else begin
              for (i = 0; i < cur_len && i < MAX_RUN && i < PAYLOAD_DEPTH; i++)
                push_result(STAT_OK, payload[i], 5'(i), (i + 1 == cur_len));
            end
          end
        end
        default: rx_phase = HUNT;
      endcase
    end
  endtask

  task automatic report(input string field, input int want, input int seen);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, seen);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      start_byte  = START_BYTE_RST;
      end_byte    = END_BYTE_RST;
      max_len     = MAX_LEN_RST;
      timeout     = TIMEOUT_RST;
      rx_phase    = HUNT;
      cur_id      = '0;
      cur_len     = '0;
      byte_count  = '0;
      run_xor     = '0;
      rx_sum      = '0;
      tick_count  = '0;
      for (int k = 0; k < PAYLOAD_DEPTH; k++) payload[k] = '0;
      awaited_results.delete();
      mismatches  = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_START_BYTE: start_byte = cfg.data;
          CFG_END_BYTE:   end_byte   = cfg.data;
          CFG_MAX_LEN:    max_len    = cfg.data[5:0];
          CFG_TIMEOUT:    timeout    = cfg.data;
          default: ;
        endcase
      end
      if (item.valid && item.ready) deframe_step(item.kind, item.data_byte);
      if (result.valid && result.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d id %0d len %0d",
                   $time, result.status, result.msg_id, result.frame_length);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status) report("status", want.status, result.status);
          if (result.msg_id !== want.msg_id) report("msg_id", want.msg_id, result.msg_id);
          if (result.frame_length !== want.frame_length)
            report("frame_length", want.frame_length, result.frame_length);
          if (result.payload_byte !== want.payload_byte)
            report("payload_byte", want.payload_byte, result.payload_byte);
          if (result.byte_index !== want.byte_index)
            report("byte_index", want.byte_index, result.byte_index);
          if (result.last !== want.last) report("last", want.last, result.last);
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the deframer testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
  import bfd_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int DRAIN_CYCLES    = 80;
  localparam int HOLD_CYCLES     = 400;

  typedef enum {
    FR_GOOD,
    FR_EMPTY,
    FR_LONG,
    FR_TIMEOUT,
    FR_BAD_END,
    FR_BAD_SUM,
    FR_CUT,
    FR_NOISE
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst;

  bfd_item_if   item ();
  bfd_result_if result ();
  bfd_cfg_if    cfg ();

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int items_sent;

  // Stimulus-side view of the registers, used to shape frames
  logic [7:0] cur_start;
  logic [7:0] cur_end;
  logic [5:0] cur_max;
  logic [7:0] cur_timeout;

  byte_frame_deframer_xor_check_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  frame_checker frames (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int seen;
    seen = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        result.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid     <= 1'b1;
    item.kind      <= kind;
    item.data_byte <= b;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(KIND_BYTE, b);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 8'($urandom));
  endtask

  // Leaves cfg.valid high; the caller drops it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sb, input logic [7:0] eb, input logic [5:0] ml,
                            input logic [7:0] to);
    write_reg(CFG_START_BYTE, sb);
    write_reg(CFG_END_BYTE, eb);
    write_reg(CFG_MAX_LEN, {2'b00, ml});
    write_reg(CFG_TIMEOUT, to);
    cfg.valid   <= 1'b0;
    cur_start   = sb;
    cur_end     = eb;
    cur_max     = ml;
    cur_timeout = to;
  endtask

  // Stop offering items, wait for every expected result, then let the block settle
  task automatic drain();
    item.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input frame_kind_t fk);
    logic [7:0] id, len, sum, b;
    int         lim, ticks_left, cut_at, i;
    if (fk == FR_NOISE) begin
      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(1) == 0) begin
          send_tick();
        end else begin
          b = 8'($urandom);
          while (b == cur_start) b = 8'($urandom);
          send_byte(b);
        end
      end
      return;
    end
    lim = cur_max;
    if (lim > LIMIT_CAP_I) lim = LIMIT_CAP_I;
    id = 8'($urandom);
    send_byte(cur_start);
    send_byte(id);
    if (fk == FR_CUT) return;
    if (fk == FR_LONG) begin
      send_byte(8'($urandom_range(255, lim + 1)));
      return;
    end
    if (fk == FR_EMPTY) len = 8'd0;
    else if ($urandom_range(7) == 0) len = 8'(lim);
    else len = 8'($urandom_range((lim < 6) ? lim : 6, 0));
    send_byte(len);
    sum        = id ^ len;
    ticks_left = (fk == FR_TIMEOUT) ? 0 : int'(cur_timeout);
    // position after the length byte where the frame is left to time out
    cut_at     = (fk == FR_TIMEOUT) ? int'($urandom_range(len + 1, 0)) : -1;
    for (i = 0; i < len + 2; i++) begin
      if (i == cut_at) begin
        repeat (int'(cur_timeout) + 1) send_tick();
        return;
      end
      if (ticks_left > 0 && $urandom_range(7) == 0) begin
        send_tick();
        ticks_left--;
      end
      if (i < len) begin
        b   = ($urandom_range(15) == 0) ? cur_start : 8'($urandom);
        sum = sum ^ b;
        send_byte(b);
      end else if (i == len) begin
        send_byte((fk == FR_BAD_SUM) ? (sum ^ 8'($urandom_range(255, 1))) : sum);
      end else begin
        send_byte((fk == FR_BAD_END) ? (cur_end ^ 8'($urandom_range(255, 1))) : cur_end);
      end
    end
  endtask

  initial begin
    int          phase_no, target, r;
    frame_kind_t fk;
    rst            <= 1'b1;
    item.valid     <= 1'b0;
    item.kind      <= KIND_BYTE;
    item.data_byte <= 8'd0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_START_BYTE;
    cfg.data       <= 8'd0;
    cur_start      = START_BYTE_RST;
    cur_end        = END_BYTE_RST;
    cur_max        = MAX_LEN_RST;
    cur_timeout    = TIMEOUT_RST;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    items_sent     = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under the reset register values
    send_byte(8'h00);
    send_tick();
    // empty frame, extreme id
    send_byte(cur_start);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_end);
    // start byte inside the payload, tick in the middle
    send_byte(cur_start);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(cur_start);
    send_byte(8'hFF);
    send_tick();
    send_byte(8'h02 ^ cur_start ^ 8'hFF);
    send_byte(cur_end);
    // length one above the limit
    send_byte(cur_start);
    send_byte(8'h12);
    send_byte(8'd33);
    // wrong end byte
    send_byte(cur_start);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(cur_end ^ 8'h01);
    // wrong checksum
    send_byte(cur_start);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(cur_end);
    drain();

    for (phase_no = 1; phase_no <= 7; phase_no++) begin
      case (phase_no)
        1: begin
          set_config(8'h00, 8'hFF, 6'd0, 8'd1);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        2: begin
          set_config(8'hFF, 8'h00, 6'd32, 8'd255);
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
        3: begin
          set_config(8'($urandom), 8'($urandom), 6'($urandom_range(32, 1)),
                     8'($urandom_range(20, 1)));
          send_idle_pct  = 0;
          recv_stall_pct = 61;
        end
        4: begin
          set_config(8'($urandom), 8'($urandom), 6'd32, 8'($urandom_range(12, 2)));
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
        5: begin
          // hold the receiver off so the block fills up and stalls its input
          set_config(8'($urandom), 8'($urandom), 6'd32, 8'($urandom_range(12, 2)));
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_requests++;
        end
        6: begin
          set_config(8'($urandom), 8'($urandom), 6'($urandom_range(32, 0)), 8'd0);
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
        default: begin
          set_config(START_BYTE_RST, END_BYTE_RST, MAX_LEN_RST, TIMEOUT_RST);
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (phase_no == 5 || r < 48) fk = FR_GOOD;
        else if (r < 56) fk = FR_EMPTY;
        else if (r < 64) fk = FR_LONG;
        else if (r < 72) fk = FR_TIMEOUT;
        else if (r < 80) fk = FR_BAD_END;
        else if (r < 88) fk = FR_BAD_SUM;
        else if (r < 93) fk = FR_CUT;
        else fk = FR_NOISE;
        // keep long tick runs out of the item budget
        if (fk == FR_TIMEOUT && cur_timeout > 24) fk = FR_BAD_END;
        if ($urandom_range(3) == 0) send_frame(FR_NOISE);
        send_frame(fk);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
